// ===== rtl/mbtq_pkg.sv =====
// Shared constants, types and helpers for the multi-buffer transmit queue.
package mbtq_pkg;

	localparam int NUM_BUFFERS  = 4;
	localparam int BUFFER_BYTES = 64;

	localparam int BUF_W  = $clog2(NUM_BUFFERS);
	localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
	localparam int ADDR_W = $clog2(NUM_BUFFERS * BUFFER_BYTES);
	localparam int CNT_W  = $clog2(NUM_BUFFERS + 1);

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_DONE  = 1'b1;

	typedef logic [BUF_W-1:0] bidx_t;
	typedef logic [LEN_W-1:0] len_t;

	// transfer command handed from front to back
	typedef struct packed {
		bidx_t bidx;
		len_t  len;
	} cmd_t;

	// byte store write port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// back reports a buffer fully read out
	typedef struct packed {
		logic  en;
		bidx_t bidx;
	} clr_t;

	function automatic bidx_t ring_next(bidx_t i);
		return (i == bidx_t'(NUM_BUFFERS - 1)) ? '0 : i + bidx_t'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] byte_addr(bidx_t b, len_t off);
		return ADDR_W'(b) * ADDR_W'(BUFFER_BYTES) + ADDR_W'(off);
	endfunction

endpackage

// ===== rtl/multi_buffer_tx_queue_core.sv =====
// Multi-buffer transmit queue: top level.
//
// Input channel (in_valid/in_ready): action 0 appends write_byte to the fill
// buffer of a ring of NUM_BUFFERS buffers of BUFFER_BYTES bytes; end_of_write
// marks the last byte of a write and starts an idle sender. Action 1 reports
// that the buffer in transfer is done: it is cleared and the next buffer starts
// if it is not empty. Overrun and full-buffer bytes are silently dropped.
// Output channel (out_valid/out_ready): one transfer per byte sent, with the
// buffer index and end_of_transfer on the last byte of a buffer.
// Throughput: one input item per cycle while the command queue has room. A write
// stalls while its buffer still has bytes queued for readout. Output runs one
// byte per cycle while the receiver is ready, set by the single read port of the
// byte store. With the back idle, the first byte of a started buffer passes the
// command queue, the read state, the read stage and the output register before
// out_valid rises. Up to NUM_BUFFERS started buffers wait in the command queue,
// so the input side keeps running while the receiver stalls.
// Reset clears all lengths and indices; the sender comes up idle.
module multi_buffer_tx_queue_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] write_byte,
	input  logic       end_of_write,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] send_byte,
	output logic [3:0] send_buffer,
	output logic       end_of_transfer
);
	import mbtq_pkg::*;

	logic fifo_full;
	logic fifo_valid;
	logic fifo_pop;
	logic push;
	cmd_t push_cmd;
	cmd_t fifo_cmd;
	wr_t  wr;
	clr_t clr;

	mbtq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.write_byte   (write_byte),
		.end_of_write (end_of_write),
		.fifo_full    (fifo_full),
		.push         (push),
		.push_cmd     (push_cmd),
		.wr           (wr),
		.clr          (clr)
	);

	mbtq_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.valid    (fifo_valid),
		.pop      (fifo_pop),
		.cmd      (fifo_cmd)
	);

	mbtq_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.fifo_valid      (fifo_valid),
		.fifo_cmd        (fifo_cmd),
		.fifo_pop        (fifo_pop),
		.wr              (wr),
		.clr             (clr),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.send_byte       (send_byte),
		.send_buffer     (send_buffer),
		.end_of_transfer (end_of_transfer)
	);

endmodule

// ===== rtl/mbtq_cmd_fifo.sv =====
// Small command queue between the front and back parts.
module mbtq_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mbtq_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          valid,
	input  logic          pop,
	output mbtq_pkg::cmd_t cmd
);
	import mbtq_pkg::*;

	cmd_t              entry_q [NUM_BUFFERS];
	bidx_t             wp_q;
	bidx_t             rp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign valid   = (cnt_q != '0);
	assign full    = (cnt_q == CNT_W'(NUM_BUFFERS));
	assign cmd     = entry_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= ring_next(wp_q);
			end
			if (do_pop) begin
				rp_q <= ring_next(rp_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/mbtq_front.sv =====
// Front part: takes items, keeps the ring bookkeeping, writes bytes, issues transfers.
module mbtq_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           action,
	input  logic [7:0]     write_byte,
	input  logic           end_of_write,
	input  logic           fifo_full,
	output logic           push,
	output mbtq_pkg::cmd_t push_cmd,
	output mbtq_pkg::wr_t  wr,
	input  mbtq_pkg::clr_t clr
);
	import mbtq_pkg::*;

	len_t                   len_q [NUM_BUFFERS];
	bidx_t                  fill_q;
	bidx_t                  send_q;
	logic                   sending_q;
	logic                   dropping_q;
	logic [NUM_BUFFERS-1:0] pending_q;

	logic  accept;
	len_t  cur_len;
	len_t  len_inc;
	logic  discard;
	logic  do_write;
	logic  buf_full;
	bidx_t fill_after;
	bidx_t start_b;
	len_t  start_len;
	logic  try_start;
	logic  start_go;

	// a write waits while its buffer still has bytes on their way out
	assign in_ready = !fifo_full && !(action == ACT_WRITE && pending_q[fill_q]);
	assign accept   = in_valid && in_ready;

	assign cur_len  = len_q[fill_q];
	assign len_inc  = cur_len + len_t'(1);
	assign discard  = dropping_q || (cur_len >= len_t'(BUFFER_BYTES))
		|| (sending_q && fill_q == send_q);
	assign do_write = accept && action == ACT_WRITE && !discard;
	assign buf_full = (len_inc == len_t'(BUFFER_BYTES));
	assign fill_after = (do_write && buf_full) ? ring_next(fill_q) : fill_q;

	assign start_b   = (action == ACT_DONE) ? ring_next(send_q) : send_q;
	assign try_start = accept && ((action == ACT_DONE && sending_q)
		|| (action == ACT_WRITE && end_of_write && !sending_q));
	// length as it stands after this item's own byte
	assign start_len = (do_write && fill_q == start_b) ? len_inc : len_q[start_b];
	assign start_go  = try_start && (start_len != '0);

	assign push          = start_go;
	assign push_cmd.bidx = start_b;
	assign push_cmd.len  = start_len;

	assign wr.en   = do_write;
	assign wr.addr = byte_addr(fill_q, cur_len);
	assign wr.data = write_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				len_q[i] <= '0;
			end
			fill_q     <= '0;
			send_q     <= '0;
			sending_q  <= 1'b0;
			dropping_q <= 1'b0;
			pending_q  <= '0;
		end else begin
			if (do_write) begin
				len_q[fill_q] <= len_inc;
			end
			if (accept && action == ACT_DONE && sending_q) begin
				len_q[send_q] <= '0;
				send_q        <= ring_next(send_q);
			end

			if (start_go && fill_after == start_b) begin
				fill_q <= ring_next(fill_after);
			end else begin
				fill_q <= fill_after;
			end

			if (try_start) begin
				sending_q <= start_go;
			end

			if (accept && action == ACT_WRITE && end_of_write) begin
				dropping_q <= 1'b0;
			end else if (do_write && buf_full && ring_next(fill_q) == send_q) begin
				dropping_q <= 1'b1;
			end

			for (int i = 0; i < NUM_BUFFERS; i++) begin
				if (push && start_b == bidx_t'(i)) begin
					pending_q[i] <= 1'b1;
				end else if (clr.en && clr.bidx == bidx_t'(i)) begin
					pending_q[i] <= 1'b0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full)
		else $error("transfer command issued into a full queue");

	a_no_write_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |-> !pending_q[fill_q])
		else $error("byte written into a buffer still being read out");

	a_sending_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_go |=> sending_q && pending_q[$past(start_b)])
		else $error("started transfer not tracked");
`endif

endmodule

// ===== rtl/mbtq_back.sv =====
// Back part: byte store and readout of queued transfers, one byte per cycle unless stalled.
module mbtq_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fifo_valid,
	input  mbtq_pkg::cmd_t fifo_cmd,
	output logic           fifo_pop,
	input  mbtq_pkg::wr_t  wr,
	output mbtq_pkg::clr_t clr,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     send_byte,
	output logic [3:0]     send_buffer,
	output logic           end_of_transfer
);
	import mbtq_pkg::*;

	logic [7:0] mem [NUM_BUFFERS * BUFFER_BYTES];

	logic  active_q;
	bidx_t cbuf_q;
	len_t  clen_q;
	len_t  off_q;

	logic       s1_valid_q;
	logic [7:0] data_s1;
	bidx_t      bidx_s1;
	logic       last_s1;

	logic       out_valid_q;
	logic [7:0] byte_q;
	bidx_t      bidx_q;
	logic       last_q;

	logic out_room;
	logic s1_move;
	logic s1_room;
	logic issue;
	logic last_rd;

	assign out_room = !out_valid_q || out_ready;
	assign s1_move  = s1_valid_q && out_room;
	assign s1_room  = !s1_valid_q || s1_move;
	assign issue    = active_q && s1_room;
	assign last_rd  = issue && ((off_q + len_t'(1)) == clen_q);
	assign fifo_pop = fifo_valid && (!active_q || last_rd);

	assign clr.en   = last_rd;
	assign clr.bidx = cbuf_q;

	assign out_valid       = out_valid_q;
	assign send_byte       = byte_q;
	assign send_buffer     = 4'(bidx_q);
	assign end_of_transfer = last_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (issue) begin
			data_s1 <= mem[byte_addr(cbuf_q, off_q)];
			bidx_s1 <= cbuf_q;
			last_s1 <= last_rd;
		end
		if (s1_move) begin
			byte_q <= data_s1;
			bidx_q <= bidx_s1;
			last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cbuf_q      <= '0;
			clen_q      <= '0;
			off_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fifo_pop) begin
				active_q <= 1'b1;
				cbuf_q   <= fifo_cmd.bidx;
				clen_q   <= fifo_cmd.len;
				off_q    <= '0;
			end else if (last_rd) begin
				active_q <= 1'b0;
			end else if (issue) begin
				off_q <= off_q + len_t'(1);
			end

			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> off_q < clen_q)
		else $error("read past the end of a buffer");

	a_cmd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |-> fifo_cmd.len != '0 && fifo_cmd.len <= len_t'(BUFFER_BYTES))
		else $error("transfer command with bad length");
`endif

endmodule

// ===== dv/multi_buffer_tx_queue_core_tb.sv =====
// Self-checking testbench for the multi-buffer transmit queue.
module multi_buffer_tx_queue_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mbtq_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int RAND_ITEMS  = 450;
	localparam int DRAIN_WAIT  = 20;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] bidx;
		logic       last;
	} tx_byte_t;

	// Tracks buffer contents and queues the bytes each transfer must put out.
	class tx_scoreboard;
		tx_byte_t   expected_q[$];
		logic [7:0] store [NUM_BUFFERS*BUFFER_BYTES];
		len_t       lens [NUM_BUFFERS];
		bidx_t      fill_idx;
		bidx_t      send_idx;
		bit         busy;
		bit         drop;
		int         errors;

		function new();
			foreach (store[i]) store[i] = '0;
			foreach (lens[i]) lens[i] = '0;
			fill_idx = '0;
			send_idx = '0;
			busy     = 1'b0;
			drop     = 1'b0;
			errors   = 0;
		endfunction

		function bidx_t next_buf(bidx_t i);
			return (i == bidx_t'(NUM_BUFFERS - 1)) ? '0 : bidx_t'(i + 1'b1);
		endfunction

		// Queue the whole buffer at send_idx; an empty buffer leaves the sender idle.
		function void start_send();
			tx_byte_t t;
			int       n;
			int       k;
			n = int'(lens[send_idx]);
			if (n == 0) begin
				busy = 1'b0;
				return;
			end
			for (k = 0; k < n; k++) begin
				t.data = store[int'(send_idx) * BUFFER_BYTES + k];
				t.bidx = 4'(send_idx);
				t.last = (k == n - 1);
				expected_q.push_back(t);
			end
			busy = 1'b1;
			if (fill_idx == send_idx)
				fill_idx = next_buf(fill_idx);
		endfunction

		// Applies one accepted item to the tracked ring state.
		function void note_input(logic act, logic [7:0] data, logic eow);
			bit keep;
			if (act == ACT_DONE) begin
				if (!busy)
					return;
				lens[send_idx] = '0;
				send_idx = next_buf(send_idx);
				start_send();
				return;
			end
			keep = !drop && (lens[fill_idx] < len_t'(BUFFER_BYTES))
				&& !(busy && fill_idx == send_idx);
			if (keep) begin
				store[int'(fill_idx) * BUFFER_BYTES + int'(lens[fill_idx])] = data;
				lens[fill_idx] = lens[fill_idx] + 1'b1;
				if (lens[fill_idx] == len_t'(BUFFER_BYTES)) begin
					fill_idx = next_buf(fill_idx);
					// ring wrapped onto the sender: rest of this write is lost
					if (fill_idx == send_idx)
						drop = 1'b1;
				end
			end
			if (eow) begin
				drop = 1'b0;
				if (!busy)
					start_send();
			end
		endfunction

		function void check_result(logic [7:0] data, logic [3:0] bidx, logic last);
			tx_byte_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transfer: byte %h buffer %0d eot %b", data, bidx, last);
				return;
			end
			want = expected_q.pop_front();
			if (want.data !== data || want.bidx !== bidx || want.last !== last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected byte %h buffer %0d eot %b, got %h %0d %b",
						want.data, want.bidx, want.last, data, bidx, last);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       action;
	logic [7:0] write_byte;
	logic       end_of_write;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] send_byte;
	logic [3:0] send_buffer;
	logic       end_of_transfer;

	tx_scoreboard board;
	int  sent_items   = 0;
	int  rx_count     = 0;
	int  cycle_cnt    = 0;
	int  quiet_cycles = 0;
	bit  tx_steady    = 1'b0;
	bit  pressure_done = 1'b0;

	multi_buffer_tx_queue_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.write_byte      (write_byte),
		.end_of_write    (end_of_write),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.send_byte       (send_byte),
		.send_buffer     (send_buffer),
		.end_of_transfer (end_of_transfer)
	);

	always #5ns clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int burst_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 6);
		if (r < 95)
			return $urandom_range(7, 40);
		return $urandom_range(130, 220);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic push_item(input logic act, input logic [7:0] data, input logic eow);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		write_byte   <= data;
		end_of_write <= eow;
		do @(posedge clk); while (!in_ready);
		board.note_input(act, data, eow);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic run_directed();
		push_item(ACT_DONE, 8'hFF, 1'b1);   // done while idle
		push_item(ACT_WRITE, 8'h00, 1'b1);  // one byte starts buffer 0
		push_item(ACT_WRITE, 8'hFF, 1'b0);
		push_item(ACT_WRITE, 8'hA5, 1'b1);  // held in buffer 1, sender busy
		push_item(ACT_DONE, 8'h00, 1'b0);
		push_item(ACT_DONE, 8'h5A, 1'b1);   // next buffer empty, sender idles
		push_item(ACT_DONE, 8'hC3, 1'b0);
		push_item(ACT_WRITE, 8'h01, 1'b0);
		push_item(ACT_WRITE, 8'h80, 1'b0);
		push_item(ACT_WRITE, 8'h7F, 1'b1);
		push_item(ACT_WRITE, 8'hFE, 1'b1);
		push_item(ACT_WRITE, 8'h3C, 1'b1);
		push_item(ACT_DONE, 8'hFF, 1'b1);
		push_item(ACT_DONE, 8'hFF, 1'b0);
		push_item(ACT_DONE, 8'h00, 1'b1);
	endtask

	task automatic run_random();
		int  r;
		int  n;
		int  k;
		logic eow;
		while (sent_items < RAND_ITEMS) begin
			tx_steady = (sent_items % 150) >= 110;
			r = $urandom_range(0, 99);
			if (r < 35) begin
				push_item(ACT_DONE, 8'($urandom), 1'($urandom));
			end else begin
				n = burst_len();
				for (k = 0; k < n && sent_items < RAND_ITEMS; k++) begin
					// long writes run uninterrupted so the ring overruns
					if (n <= 40 && $urandom_range(0, 24) == 0)
						push_item(ACT_DONE, 8'($urandom), 1'($urandom));
					eow = (k == n - 1) && (r < 90);
					push_item(ACT_WRITE, 8'($urandom), eow);
				end
			end
		end
	endtask

	// Receiver: random stalls, steady windows, and one long hold-off.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!pressure_done && rx_count >= 80) begin
				pressure_done = 1'b1;
				stall_left    = 399;
				out_ready <= 1'b0;
			end else if ((cycle_cnt % 1024) < 160) begin
				out_ready <= 1'b1;
			end else begin
				stall_left = pick_gap();
				out_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_result(send_byte, send_buffer, end_of_transfer);
			rx_count++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_cnt++;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		board        = new();
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_WRITE;
		write_byte   = '0;
		end_of_write = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		sent_items = 0;
		run_random();
		in_valid <= 1'b0;
		while (board.expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
